[hw/rtl/fahq_pkg.sv]
// Shared types and constants for the four-ary min-heap priority queue.
// Holds the entry layout, operation and status codes and the controller states.
// No dependencies.
package fahq_pkg;

	// Fixed field widths of the stream items
	localparam int KEY_BITS     = 16;
	localparam int PAYLOAD_BITS = 16;
	localparam int OCC_BITS     = 11;
	localparam int S_DATA_BITS  = 32;
	localparam int M_DATA_BITS  = 48;
	localparam int M_USER_BITS  = 3;

	// Defaults for the top-level parameters
	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_ARITY    = 4;

	// Operation codes carried in s_tuser
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Heap entry, key in the low bits
	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] payload;
		logic [KEY_BITS-1:0]     key;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CMP,
		ST_UP_FIN,
		ST_DN_ROOT,
		ST_DN_LAST,
		ST_DN_LEVEL,
		ST_DN_SCAN,
		ST_DN_DECIDE,
		ST_RESULT
	} state_t;

endpackage

[hw/rtl/four_ary_min_heap_queue.sv]
// A push climbs level by level while strictly smaller than its parent; a pop scans the children
// of each level and sinks while larger than the smallest, stops at a leaf, and skips the scan
// when it empties the heap; a pop on empty or a push on full goes straight to the result.
// Throughput: one item at a time; the next item is accepted the cycle after the result loads,
// and a result the sink has not taken holds the controller in its result state.
// Reset clears the entry count and the handshake state; heap memory is not cleared.
// Top level of the d-ary min-heap priority queue: controller plus heap memory.
// Depends on fahq_pkg.
module four_ary_min_heap_queue
	import fahq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ARITY    = DEF_ARITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_BITS-1:0] s_tdata,  // entry_key[15:0], entry_payload[31:16]
	input  logic                   s_tuser,  // operation[0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_BITS-1:0] m_tdata,  // popped_key[15:0], popped_payload[31:16],
	                                         // occupancy[42:32], zero[47:43]
	output logic [M_USER_BITS-1:0] m_tuser   // popped_valid[0], status[2:1]
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CH_W  = IDX_W + $clog2(ARITY) + 1;
	localparam int ISS_W = $clog2(ARITY + 1);

	// Heap memory with registered read data
	entry_t             heap_mem [CAPACITY];
	entry_t             rdata_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               m_tvalid_q;

	entry_t             cur_q;
	entry_t             best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               first_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   par_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [CH_W-1:0]    nxt_q;
	logic [ISS_W-1:0]   iss_q;

	logic [KEY_BITS-1:0]     res_key_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic                    res_valid_q;
	status_t                 res_status_q;
	logic [M_DATA_BITS-1:0]  m_tdata_q;
	logic [M_USER_BITS-1:0]  m_tuser_q;

	logic               accept;
	logic               is_pop;
	logic               full;
	logic               empty;
	logic               up_less;
	logic [IDX_W-1:0]   grand_par;
	logic [IDX_W-1:0]   push_par;
	logic [CH_W-1:0]    first_ch;
	logic               has_child;
	logic               scan_more;
	logic               out_free;
	entry_t             in_entry;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_pop    = (s_tuser == OP_POP);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign in_entry  = entry_t'(s_tdata);
	assign out_free  = !m_tvalid_q || m_tready;

	// Heap index arithmetic
	assign push_par  = IDX_W'((count_q - CNT_W'(1)) / ARITY);
	assign grand_par = IDX_W'((par_q - IDX_W'(1)) / ARITY);
	assign up_less   = (cur_q.key < rdata_q.key);
	assign first_ch  = CH_W'(pos_q) * CH_W'(ARITY) + CH_W'(1);
	assign has_child = (first_ch < CH_W'(count_q));
	assign scan_more = (iss_q < ISS_W'(ARITY)) && (nxt_q < CH_W'(count_q));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_pop) begin
						state_d = empty ? ST_RESULT : ST_DN_ROOT;
					end else if (full) begin
						state_d = ST_RESULT;
					end else begin
						state_d = empty ? ST_UP_FIN : ST_UP_CMP;
					end
				end
			end
			ST_UP_CMP: begin
				if (!up_less) begin
					state_d = ST_RESULT;
				end else if (par_q == '0) begin
					state_d = ST_UP_FIN;
				end
			end
			ST_UP_FIN:    state_d = ST_RESULT;
			ST_DN_ROOT:   state_d = (count_q == '0) ? ST_RESULT : ST_DN_LAST;
			ST_DN_LAST:   state_d = ST_DN_LEVEL;
			ST_DN_LEVEL:  state_d = has_child ? ST_DN_SCAN : ST_RESULT;
			ST_DN_SCAN:   state_d = scan_more ? ST_DN_SCAN : ST_DN_DECIDE;
			ST_DN_DECIDE: state_d = (cur_q.key > best_q.key) ? ST_DN_LEVEL : ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_pop && !empty) begin
					rd_en = 1'b1;
				end else if (accept && !is_pop && !full && !empty) begin
					rd_en   = 1'b1;
					rd_addr = push_par;
				end
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (up_less) begin
					wr_data = rdata_q;
					if (par_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = grand_par;
					end
				end
			end
			ST_UP_FIN: begin
				wr_en = 1'b1;
			end
			ST_DN_ROOT: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(count_q);
			end
			ST_DN_LEVEL: begin
				if (has_child) begin
					rd_en   = 1'b1;
					rd_addr = first_ch[IDX_W-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			ST_DN_SCAN: begin
				if (scan_more) begin
					rd_en   = 1'b1;
					rd_addr = nxt_q[IDX_W-1:0];
				end
			end
			ST_DN_DECIDE: begin
				wr_en = 1'b1;
				if (cur_q.key > best_q.key) begin
					wr_data = best_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Heap memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= heap_mem[rd_addr];
		end
	end

	// Control state: controller, entry count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_pop && !empty) begin
				count_q <= count_q - CNT_W'(1);
			end else if (accept && !is_pop && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_q <= rd_addr;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_key_q   <= '0;
					res_pay_q   <= '0;
					res_valid_q <= 1'b0;
					cur_q       <= in_entry;
					pos_q       <= IDX_W'(count_q);
					par_q       <= push_par;
					if (is_pop) begin
						res_status_q <= empty ? STATUS_EMPTY : STATUS_OK;
					end else begin
						res_status_q <= full ? STATUS_FULL : STATUS_OK;
					end
				end
			end
			ST_UP_CMP: begin
				if (up_less) begin
					pos_q <= par_q;
					par_q <= grand_par;
				end
			end
			ST_DN_ROOT: begin
				res_key_q   <= rdata_q.key;
				res_pay_q   <= rdata_q.payload;
				res_valid_q <= 1'b1;
			end
			ST_DN_LAST: begin
				cur_q <= rdata_q;
				pos_q <= '0;
			end
			ST_DN_LEVEL: begin
				first_q <= 1'b1;
				nxt_q   <= first_ch + CH_W'(1);
				iss_q   <= ISS_W'(1);
			end
			ST_DN_SCAN: begin
				// keep the smallest child, leftmost on ties
				if (first_q || rdata_q.key < best_q.key) begin
					best_q     <= rdata_q;
					best_idx_q <= rd_idx_q;
				end
				first_q <= 1'b0;
				if (scan_more) begin
					nxt_q <= nxt_q + CH_W'(1);
					iss_q <= iss_q + ISS_W'(1);
				end
			end
			ST_DN_DECIDE: begin
				pos_q <= best_idx_q;
			end
			ST_RESULT: begin
				if (out_free) begin
					m_tdata_q <= M_DATA_BITS'({OCC_BITS'(count_q), res_pay_q, res_key_q});
					m_tuser_q <= {res_status_q, res_valid_q};
				end
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[tb/sv/tb_four_ary_min_heap_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the four-ary min-heap priority queue.
// Keeps its own heap to predict each result; depends on fahq_pkg and the queue top level.
module tb_four_ary_min_heap_queue;
	import fahq_pkg::*;

	localparam int CAPACITY    = DEF_CAPACITY;
	localparam int ARITY       = DEF_ARITY;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 40;

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    found;
		status_t                 status;
		logic [OCC_BITS-1:0]     occupancy;
	} outcome_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata;  // entry_key[15:0], entry_payload[31:16]
	logic                   s_tuser;  // operation[0]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_DATA_BITS-1:0] m_tdata;  // popped_key[15:0], popped_payload[31:16],
	                                  // occupancy[42:32], zero[47:43]
	logic [M_USER_BITS-1:0] m_tuser;  // popped_valid[0], status[2:1]

	// Shadow heap and the results it predicts
	entry_t      heap_mem [CAPACITY];
	int unsigned heap_count = 0;
	outcome_t    pending_results [$];

	// Stimulus state
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int sent_level    = 0;

	// Run statistics
	int items_accepted  = 0;
	int results_checked = 0;
	int pops_returned   = 0;
	int empty_pops      = 0;
	int full_pushes     = 0;
	int peak_occupancy  = 0;
	int error_count     = 0;
	int quiet_cycles    = 0;

	four_ary_min_heap_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Apply one operation to the shadow heap and return the result it should give
	function automatic outcome_t heap_apply(logic op, logic [KEY_BITS-1:0] new_key,
	                                        logic [PAYLOAD_BITS-1:0] new_payload);
		outcome_t    res;
		entry_t      tmp;
		int unsigned pos;
		int unsigned parent;
		int unsigned first;
		int unsigned best;
		res = '0;
		res.status = STATUS_OK;
		if (op == OP_PUSH) begin
			if (heap_count >= CAPACITY) begin
				res.status = STATUS_FULL;
			end else begin
				pos = heap_count;
				heap_mem[pos].key = new_key;
				heap_mem[pos].payload = new_payload;
				// climb while strictly smaller than the parent
				while (pos > 0) begin
					parent = (pos - 1) / ARITY;
					if (heap_mem[pos].key >= heap_mem[parent].key)
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[parent];
					heap_mem[parent] = tmp;
					pos = parent;
				end
				heap_count++;
			end
		end else if (heap_count == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			res.key = heap_mem[0].key;
			res.payload = heap_mem[0].payload;
			res.found = 1'b1;
			heap_mem[0] = heap_mem[heap_count - 1];
			heap_count--;
			// sink: leftmost smallest child, swap only on strictly greater parent
			pos = 0;
			forever begin
				first = ARITY * pos + 1;
				if (first >= heap_count)
					break;
				best = first;
				for (int unsigned c = first + 1; c < first + ARITY && c < heap_count; c++)
					if (heap_mem[c].key < heap_mem[best].key)
						best = c;
				if (heap_mem[pos].key <= heap_mem[best].key)
					break;
				tmp = heap_mem[pos];
				heap_mem[pos] = heap_mem[best];
				heap_mem[best] = tmp;
				pos = best;
			end
		end
		res.occupancy = heap_count[OCC_BITS-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
		         what, got, want, results_checked, $time);
		error_count++;
	endtask

	// Predict on each accepted item, then check each accepted result
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(heap_apply(s_tuser, s_tdata[15:0], s_tdata[31:16]));
				items_accepted++;
				if (heap_count > peak_occupancy)
					peak_occupancy = heap_count;
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[15:0] !== want.key)
						report_mismatch("popped_key", 32'(m_tdata[15:0]), 32'(want.key));
					if (m_tdata[31:16] !== want.payload)
						report_mismatch("popped_payload", 32'(m_tdata[31:16]),
						                32'(want.payload));
					if (m_tdata[42:32] !== want.occupancy)
						report_mismatch("occupancy", 32'(m_tdata[42:32]),
						                32'(want.occupancy));
					if (m_tdata[47:43] !== '0)
						report_mismatch("tdata padding", 32'(m_tdata[47:43]), 32'd0);
					if (m_tuser[0] !== want.found)
						report_mismatch("popped_valid", 32'(m_tuser[0]), 32'(want.found));
					if (m_tuser[2:1] !== want.status)
						report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
					if (want.found)
						pops_returned++;
					if (want.status == STATUS_EMPTY)
						empty_pops++;
					if (want.status == STATUS_FULL)
						full_pushes++;
				end
				results_checked++;
			end
		end
	end

	// Receiver: long hold-off when requested, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// Offer one item and hold it until accepted
	task automatic send_item(logic op, logic [KEY_BITS-1:0] key_val,
	                         logic [PAYLOAD_BITS-1:0] payload_val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {payload_val, key_val};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_PUSH && sent_level < CAPACITY)
			sent_level++;
		else if (op == OP_POP && sent_level > 0)
			sent_level--;
	endtask

	// Keys lean toward a few small values so that ties are common
	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(7))
			0, 1: return KEY_BITS'($urandom_range(7));
			2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return KEY_BITS'($urandom);
		endcase
	endfunction

	// Drop the offer, then wait until every accepted item has its result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty pop, key and payload extremes, equal keys, then drain past empty
	task automatic test_directed();
		set_idling(0, 0);
		send_item(OP_POP, 16'h0000, 16'h0000);
		send_item(OP_PUSH, 16'hFFFF, 16'h0000);
		send_item(OP_PUSH, 16'h0000, 16'hFFFF);
		for (int i = 1; i <= 5; i++)
			send_item(OP_PUSH, 16'h1234, i[15:0]);
		send_item(OP_PUSH, 16'h8000, 16'hAAAA);
		send_item(OP_PUSH, 16'h0001, 16'h5555);
		for (int i = 0; i < 10; i++)
			send_item(OP_POP, 16'hFFFF, 16'hFFFF);
		wait_drained();
	endtask

	// Fill to capacity, push into the full heap, then pop part of it back out
	task automatic test_fill_to_capacity();
		set_idling(0, 0);
		for (int i = 0; i < CAPACITY; i++)
			send_item(OP_PUSH, pick_key(), PAYLOAD_BITS'($urandom));
		send_item(OP_PUSH, 16'h0000, 16'hFFFF);
		send_item(OP_PUSH, 16'hFFFF, 16'h0000);
		send_item(OP_PUSH, KEY_BITS'($urandom), PAYLOAD_BITS'($urandom));
		for (int i = 0; i < 60; i++)
			send_item(OP_POP, KEY_BITS'($urandom), PAYLOAD_BITS'($urandom));
		wait_drained();
	endtask

	// Hold the output off for a long stretch while items keep coming
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_left = 400;
		for (int i = 0; i < 30; i++)
			send_item(($urandom_range(2) == 0) ? OP_POP : OP_PUSH, pick_key(),
			          PAYLOAD_BITS'($urandom));
		wait_drained();
	endtask

	// Random push/pop walk toward changing depth targets
	task automatic test_random_mix(int send_pct, int recv_pct, int count);
		int  target;
		int  sent;
		logic op;
		set_idling(send_pct, recv_pct);
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(3))
				0: target = $urandom_range(4);
				1: target = $urandom_range(60, 10);
				2: target = $urandom_range(400, 100);
				default: target = $urandom_range(12, 1);
			endcase
			for (int i = 0; i < 40 && sent < count; i++) begin
				if (sent_level < target)
					op = ($urandom_range(99) < 80) ? OP_PUSH : OP_POP;
				else
					op = ($urandom_range(99) < 20) ? OP_PUSH : OP_POP;
				send_item(op, pick_key(), PAYLOAD_BITS'($urandom));
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_PUSH;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_to_capacity();
		test_backpressure();
		test_random_mix(0, 0, 30);
		test_random_mix(56, 0, 30);
		test_random_mix(0, 56, 30);
		test_random_mix(6, 6, 30);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);

		$display("Run covered %0d items and %0d checked results, %0d entries popped",
		         items_accepted, results_checked, pops_returned);
		$display("Saw %0d pops on empty, %0d pushes on full, peak occupancy %0d",
		         empty_pops, full_pushes, peak_occupancy);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/fahq_pkg.sv
hw/rtl/four_ary_min_heap_queue.sv
tb/sv/tb_four_ary_min_heap_queue.sv
